FILE: src/qrs_pkg.sv
// Package for the quadratic root solver: widths, latencies, kind codes and
// the request, job and result structs. No dependencies.
package qrs_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int PROD_W   = 2 * DATA_WIDTH;
  localparam int DISC_W   = PROD_W + 3;
  localparam int MAG_W    = PROD_W + 1;
  localparam int SQRT_W   = (MAG_W + 2 * FRAC_BITS + 1) / 2;
  localparam int RAD_W    = 2 * SQRT_W;
  localparam int NUM_W    = SQRT_W + 3;
  localparam int DEN_W    = DATA_WIDTH + 1;
  localparam int SQRT_LAT = SQRT_W + 1;
  localparam int DIV_LAT  = DATA_WIDTH + 1;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int FIFO_SLACK = 4;

  localparam logic [DATA_WIDTH-1:0] Q_HALF = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_TWO    = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_NONE   = 2'd2,
    KIND_DEGEN  = 2'd3
  } kind_t;

  typedef logic signed [DATA_WIDTH-1:0] coef_t;

  typedef struct packed {
    coef_t coef_a;
    coef_t coef_b;
    coef_t coef_c;
  } in_item_t;

  typedef struct packed {
    coef_t root_low;
    coef_t root_high;
    kind_t root_kind;
    logic  saturated;
  } out_item_t;

  typedef struct packed {
    kind_t                    kind;
    logic [MAG_W-1:0]         disc_mag;
    logic signed [NUM_W-1:0]  neg_b;
    logic [DEN_W-1:0]         den;
    logic                     a_neg;
  } job_t;

  typedef struct packed {
    logic almost_full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: src/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on qrs_pkg.
module qrs_sqrt (
  input  logic                      clk,
  input  logic [qrs_pkg::RAD_W-1:0]  rad_in,
  output logic [qrs_pkg::SQRT_W-1:0] root_out
);
  import qrs_pkg::*;

  logic [RAD_W-1:0]  rad_r  [SQRT_W];
  logic [SQRT_W+1:0] rem_r  [SQRT_W+1];
  logic [SQRT_W-1:0] root_r [SQRT_W+1];

  always_ff @(posedge clk) begin
    rad_r[0]  <= rad_in;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
  end

  for (genvar k = 0; k < SQRT_W; k++) begin : g_stage
    logic [SQRT_W+3:0] acc;
    logic [SQRT_W+3:0] trial;
    logic              ge;

    always_comb begin
      acc   = {rem_r[k], rad_r[k][RAD_W-1-2*k -: 2]};
      trial = (SQRT_W+4)'({root_r[k], 2'b01});
      ge    = (acc >= trial);
    end

    // keep the remainder below 2*root+1 so it fits its register
    always_ff @(posedge clk) begin
      rem_r[k+1]  <= (SQRT_W+2)'(ge ? acc - trial : acc);
      root_r[k+1] <= {root_r[k][SQRT_W-2:0], ge};
    end

    if (k < SQRT_W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        rad_r[k+1] <= rad_r[k];
      end
    end
  end

  assign root_out = root_r[SQRT_W];

endmodule

FILE: src/qrs_div.sv
// Pipelined restoring divider: low quotient bits plus an overflow flag when
// the quotient does not fit DATA_WIDTH bits. Depends on qrs_pkg.
module qrs_div (
  input  logic                          clk,
  input  logic [qrs_pkg::NUM_W-1:0]      num,
  input  logic [qrs_pkg::DEN_W-1:0]      den,
  output logic [qrs_pkg::DATA_WIDTH-1:0] quo,
  output logic                          ovf
);
  import qrs_pkg::*;

  logic [DEN_W-1:0]      rem_r  [DATA_WIDTH];
  logic [DEN_W-1:0]      den_r  [DATA_WIDTH];
  logic [DATA_WIDTH-1:0] nlow_r [DATA_WIDTH];
  logic [DATA_WIDTH-1:0] q_r    [DATA_WIDTH+1];
  logic                  ovf_r  [DATA_WIDTH+1];
  logic [NUM_W-1:0]      num_hi;
  logic                  big;

  always_comb begin
    num_hi = num >> DATA_WIDTH;
    big    = (num_hi >= NUM_W'(den));
  end

  always_ff @(posedge clk) begin
    ovf_r[0]  <= big;
    rem_r[0]  <= big ? '0 : DEN_W'(num_hi);
    den_r[0]  <= den;
    nlow_r[0] <= num[DATA_WIDTH-1:0];
    q_r[0]    <= '0;
  end

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;

    always_comb begin
      trial = {rem_r[k], nlow_r[k][DATA_WIDTH-1-k]};
      ge    = (trial >= {1'b0, den_r[k]});
    end

    always_ff @(posedge clk) begin
      q_r[k+1]   <= {q_r[k][DATA_WIDTH-2:0], ge};
      ovf_r[k+1] <= ovf_r[k];
    end

    if (k < DATA_WIDTH - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        rem_r[k+1]  <= DEN_W'(ge ? trial - {1'b0, den_r[k]} : trial);
        den_r[k+1]  <= den_r[k];
        nlow_r[k+1] <= nlow_r[k];
      end
    end
  end

  assign quo = q_r[DATA_WIDTH];
  assign ovf = ovf_r[DATA_WIDTH];

endmodule

FILE: src/qrs_fifo.sv
// Small job queue between the front and back parts.
// Depends on qrs_pkg.
module qrs_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  qrs_pkg::job_t       din,
  input  logic                pop,
  output qrs_pkg::job_t       dout,
  output qrs_pkg::fifo_stat_t stat
);
  import qrs_pkg::*;

  job_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + FIFO_CW'(push) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout             = mem_r[rd_ptr_r];
  assign stat.empty       = (cnt_r == '0);
  assign stat.almost_full = (cnt_r > FIFO_CW'(FIFO_DEPTH - FIFO_SLACK));

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r < FIFO_CW'(FIFO_DEPTH))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("job queue underflow");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("job queue count out of range");

endmodule

FILE: src/qrs_front.sv
// Front part: register coefficients, form b*b and a*c, build the
// discriminant and classify the request. Depends on qrs_pkg.
module qrs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  qrs_pkg::in_item_t in_item,
  output logic              push,
  output qrs_pkg::job_t     job
);
  import qrs_pkg::*;

  logic                     v1_r, v2_r;
  in_item_t                 c1_r;
  coef_t                    a2_r, b2_r;
  logic signed [PROD_W-1:0] bb_r, ac_r;
  logic signed [DISC_W-1:0] disc;
  logic [DATA_WIDTH-1:0]    abs_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_r <= in_item;
    a2_r <= c1_r.coef_a;
    b2_r <= c1_r.coef_b;
    bb_r <= c1_r.coef_b * c1_r.coef_b;
    ac_r <= c1_r.coef_a * c1_r.coef_c;
  end

  always_comb begin
    disc  = DISC_W'(bb_r) - (DISC_W'(ac_r) <<< 2);
    abs_a = a2_r[DATA_WIDTH-1] ? DATA_WIDTH'(-a2_r) : a2_r;
    if (a2_r == '0) begin
      job.kind = KIND_DEGEN;
    end else if (disc[DISC_W-1]) begin
      job.kind = KIND_NONE;
    end else if (disc == '0) begin
      job.kind = KIND_DOUBLE;
    end else begin
      job.kind = KIND_TWO;
    end
    job.disc_mag = MAG_W'(disc);
    job.neg_b    = -(NUM_W'(b2_r)) <<< FRAC_BITS;
    job.den      = {abs_a, 1'b0};
    job.a_neg    = a2_r[DATA_WIDTH-1];
  end

  assign push = v2_r;

endmodule

FILE: src/qrs_back.sv
// Back part: square root, the two numerators, two dividers and the final
// saturation. Depends on qrs_pkg, qrs_sqrt and qrs_div.
module qrs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_vld,
  input  qrs_pkg::job_t      job,
  output logic               out_valid,
  output qrs_pkg::out_item_t out_item
);
  import qrs_pkg::*;

  logic [RAD_W-1:0]        rad;
  logic [SQRT_W-1:0]       sq_root;
  logic                    s_vld_r [SQRT_LAT];
  job_t                    s_job_r [SQRT_LAT];
  logic signed [NUM_W-1:0] s_ext, lo, hi;
  logic                    m_vld_r;
  kind_t                   m_kind_r;
  logic [NUM_W-1:0]        m_lo_r, m_hi_r;
  logic                    m_lo_neg_r, m_hi_neg_r;
  logic [DEN_W-1:0]        m_den_r;
  logic                    d_vld_r    [DIV_LAT];
  kind_t                   d_kind_r   [DIV_LAT];
  logic                    d_lo_neg_r [DIV_LAT];
  logic                    d_hi_neg_r [DIV_LAT];
  logic [DATA_WIDTH-1:0]   q_lo, q_hi;
  logic                    ovf_lo, ovf_hi;
  logic                    sat_lo, sat_hi;
  coef_t                   r_lo, r_hi;
  logic                    out_valid_r;
  out_item_t               out_item_r;

  function automatic logic clip(input logic [DATA_WIDTH-1:0] q, input logic ovf,
                                input logic neg);
    clip = ovf || (neg ? (q > Q_HALF) : (q > ~Q_HALF));
  endfunction

  function automatic coef_t finish(input logic [DATA_WIDTH-1:0] q, input logic sat,
                                   input logic neg);
    if (sat) begin
      finish = neg ? Q_HALF : ~Q_HALF;
    end else begin
      finish = neg ? -q : q;
    end
  endfunction

  assign rad = RAD_W'({job.disc_mag, {(2*FRAC_BITS){1'b0}}});

  qrs_sqrt u_sqrt (
    .clk     (clk),
    .rad_in  (rad),
    .root_out(sq_root)
  );

  // carry the job alongside the root pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_LAT; k++) s_vld_r[k] <= 1'b0;
    end else begin
      s_vld_r[0] <= job_vld;
      for (int k = 1; k < SQRT_LAT; k++) s_vld_r[k] <= s_vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    s_job_r[0] <= job;
    for (int k = 1; k < SQRT_LAT; k++) s_job_r[k] <= s_job_r[k-1];
  end

  always_comb begin
    s_ext = $signed(NUM_W'(sq_root));
    lo    = s_job_r[SQRT_LAT-1].neg_b - s_ext;
    hi    = s_job_r[SQRT_LAT-1].neg_b + s_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= s_vld_r[SQRT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    m_kind_r   <= s_job_r[SQRT_LAT-1].kind;
    m_lo_r     <= lo[NUM_W-1] ? NUM_W'(-lo) : NUM_W'(lo);
    m_hi_r     <= hi[NUM_W-1] ? NUM_W'(-hi) : NUM_W'(hi);
    m_lo_neg_r <= lo[NUM_W-1] ^ s_job_r[SQRT_LAT-1].a_neg;
    m_hi_neg_r <= hi[NUM_W-1] ^ s_job_r[SQRT_LAT-1].a_neg;
    m_den_r    <= s_job_r[SQRT_LAT-1].den;
  end

  qrs_div u_div_lo (
    .clk(clk),
    .num(m_lo_r),
    .den(m_den_r),
    .quo(q_lo),
    .ovf(ovf_lo)
  );

  qrs_div u_div_hi (
    .clk(clk),
    .num(m_hi_r),
    .den(m_den_r),
    .quo(q_hi),
    .ovf(ovf_hi)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) d_vld_r[k] <= 1'b0;
    end else begin
      d_vld_r[0] <= m_vld_r;
      for (int k = 1; k < DIV_LAT; k++) d_vld_r[k] <= d_vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    d_kind_r[0]   <= m_kind_r;
    d_lo_neg_r[0] <= m_lo_neg_r;
    d_hi_neg_r[0] <= m_hi_neg_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      d_kind_r[k]   <= d_kind_r[k-1];
      d_lo_neg_r[k] <= d_lo_neg_r[k-1];
      d_hi_neg_r[k] <= d_hi_neg_r[k-1];
    end
  end

  always_comb begin
    sat_lo = clip(q_lo, ovf_lo, d_lo_neg_r[DIV_LAT-1]);
    sat_hi = clip(q_hi, ovf_hi, d_hi_neg_r[DIV_LAT-1]);
    r_lo   = finish(q_lo, sat_lo, d_lo_neg_r[DIV_LAT-1]);
    r_hi   = finish(q_hi, sat_hi, d_hi_neg_r[DIV_LAT-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d_vld_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_item_r.root_kind <= d_kind_r[DIV_LAT-1];
    if (d_kind_r[DIV_LAT-1] == KIND_TWO || d_kind_r[DIV_LAT-1] == KIND_DOUBLE) begin
      out_item_r.root_low  <= r_lo;
      out_item_r.root_high <= r_hi;
      out_item_r.saturated <= sat_lo | sat_hi;
    end else begin
      out_item_r.root_low  <= '0;
      out_item_r.root_high <= '0;
      out_item_r.saturated <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: src/quadratic_root_solver.sv
// Quadratic root solver on Q16.16 data: a request passes the front part, the job
// queue, the square root, a numerator register, both dividers and an output
// register. Throughput is one request per cycle while busy is low; the square
// root and both dividers are fully pipelined with one result bit per stage, so
// they set the depth. Synchronous active-low reset clears all valid bits and the
// queue; results are strobed once on out_valid and the receiver cannot stall them.
module quadratic_root_solver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  qrs_pkg::in_item_t  in_item,
  output logic               out_valid,
  output qrs_pkg::out_item_t out_item
);
  import qrs_pkg::*;

  logic       accept;
  logic       push;
  logic       pop;
  job_t       job_in, job_out;
  fifo_stat_t fifo_stat;

  // take a request whenever the queue has room for what is still in flight
  assign busy   = fifo_stat.almost_full;
  assign accept = start && !busy;

  // front part: multiply and classify
  qrs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .in_item(in_item),
    .push   (push),
    .job    (job_in)
  );

  // queue between the parts; the back part drains it every cycle
  qrs_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .din  (job_in),
    .pop  (pop),
    .dout (job_out),
    .stat (fifo_stat)
  );

  assign pop = !fifo_stat.empty;

  // back part: square root, division, saturation
  qrs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_vld  (pop),
    .job      (job_out),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.root_kind == KIND_NONE || out_item.root_kind == KIND_DEGEN)
      |-> out_item.root_low == '0 && out_item.root_high == '0 && !out_item.saturated)
    else $error("no-root result carries data");

  a_double_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.root_kind == KIND_DOUBLE
      |-> out_item.root_low == out_item.root_high)
    else $error("double root differs");

  a_busy_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_stat.empty |-> !busy)
    else $error("busy with empty queue");

endmodule

FILE: sim/qrs_root_checker.sv
`timescale 1ns / 1ps
// Root checker for the quadratic root solver: watches the request and result
// channels, predicts each result and compares it. Depends on qrs_pkg.
module qrs_root_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  qrs_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  qrs_pkg::out_item_t out_item,
  output int                 mismatches,
  output int                 roots_pending,
  output int                 roots_checked
);
  import qrs_pkg::*;

  typedef logic [127:0] mag_t;

  out_item_t expected_roots[$];

  initial begin
    mismatches    = 0;
    roots_pending = 0;
    roots_checked = 0;
  end

  // Add two sign/magnitude values; zero is never negative.
  function automatic void sm_add(input mag_t am, input bit an, input mag_t bm, input bit bn,
                                 output mag_t rm, output bit rn);
    if (an == bn) begin
      rm = am + bm;
      rn = an;
    end else if (am >= bm) begin
      rm = am - bm;
      rn = an;
    end else begin
      rm = bm - am;
      rn = bn;
    end
    if (rm == 0) rn = 1'b0;
  endfunction

  // Truncating divide, then clip to the signed coefficient range.
  function automatic coef_t clip_quotient(input mag_t nm, input bit nn, input mag_t dm,
                                          input bit dn, inout bit sat);
    mag_t q;
    mag_t lim;
    bit   neg;
    neg = (nn != dn);
    q   = nm / dm;
    lim = neg ? (mag_t'(1) << (DATA_WIDTH - 1)) : ((mag_t'(1) << (DATA_WIDTH - 1)) - 1);
    if (q > lim) begin
      sat = 1'b1;
      return neg ? coef_t'(Q_HALF) : coef_t'(~Q_HALF);
    end
    return neg ? coef_t'(-q) : coef_t'(q);
  endfunction

  function automatic out_item_t solve_quadratic(input in_item_t req);
    out_item_t res;
    longint    la, lb, lc;
    mag_t      am, bm, cm, b2, ac, d, x, den, ds, s, t, lo, hi;
    bit        an, bn, cn, acn, dn, xn, lon, hin, sat;
    la  = req.coef_a;
    lb  = req.coef_b;
    lc  = req.coef_c;
    an  = la < 0;
    bn  = lb < 0;
    cn  = lc < 0;
    am  = an ? mag_t'(-la) : mag_t'(la);
    bm  = bn ? mag_t'(-lb) : mag_t'(lb);
    cm  = cn ? mag_t'(-lc) : mag_t'(lc);
    sat = 1'b0;
    res = '0;
    if (am == 0) begin
      res.root_kind = KIND_DEGEN;
      return res;
    end
    b2  = bm * bm;
    ac  = (am * cm) << 2;
    acn = (an != cn) && (ac != 0);
    sm_add(b2, 1'b0, ac, !acn, d, dn);
    if (dn) begin
      res.root_kind = KIND_NONE;
      return res;
    end
    x   = bm << FRAC_BITS;
    xn  = !bn && (x != 0);
    den = am << 1;
    if (d == 0) begin
      res.root_low  = clip_quotient(x, xn, den, an, sat);
      res.root_high = res.root_low;
      res.root_kind = KIND_DOUBLE;
    end else begin
      ds = d << (2 * FRAC_BITS);
      s  = '0;
      for (int i = DATA_WIDTH + FRAC_BITS + 1; i >= 0; i--) begin
        t = s | (mag_t'(1) << i);
        if (t * t <= ds) s = t;
      end
      sm_add(x, xn, s, 1'b1, lo, lon);
      sm_add(x, xn, s, 1'b0, hi, hin);
      res.root_low  = clip_quotient(lo, lon, den, an, sat);
      res.root_high = clip_quotient(hi, hin, den, an, sat);
      res.root_kind = KIND_TWO;
    end
    res.saturated = sat;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (start && !busy) expected_roots.push_back(solve_quadratic(in_item));
      if (out_valid) begin
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected result", longint'(out_item.root_low), 0);
        end else begin
          want = expected_roots.pop_front();
          roots_checked++;
          if (out_item.root_low !== want.root_low)
            report_mismatch("root_low", out_item.root_low, want.root_low);
          if (out_item.root_high !== want.root_high)
            report_mismatch("root_high", out_item.root_high, want.root_high);
          if (out_item.root_kind !== want.root_kind)
            report_mismatch("root_kind", out_item.root_kind, want.root_kind);
          if (out_item.saturated !== want.saturated)
            report_mismatch("saturated", out_item.saturated, want.saturated);
        end
      end
    end
    roots_pending <= expected_roots.size();
  end

endmodule

FILE: sim/tb_quadratic_root_solver.sv
`timescale 1ns / 1ps
// Testbench top for the quadratic root solver: drives coefficient requests in
// bursts and gives the verdict. Depends on qrs_pkg, qrs_root_checker and the DUT.
module tb_quadratic_root_solver;
  import qrs_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 120;   // beyond the pipeline depth
  localparam int RANDOM_ITEMS = 450;
  localparam int Q_ONE        = 1 << FRAC_BITS;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  int        mismatches, roots_pending, roots_checked;
  int        cycles = 0;
  int        sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  quadratic_root_solver dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  qrs_root_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .mismatches   (mismatches),
    .roots_pending(roots_pending),
    .roots_checked(roots_checked)
  );

  // Watchdog: end the run if the block stops answering.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one request and hold it until an edge where busy was low.
  task automatic send_request(input coef_t a, input coef_t b, input coef_t c);
    in_item <= '{coef_a: a, coef_b: b, coef_c: c};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Drop start and idle for a number of cycles.
  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Random coefficient in +/- range units of Q16.16, with a random fraction.
  function automatic coef_t small_q(input int range);
    return coef_t'($signed($urandom_range(0, 2 * range * Q_ONE)) - range * Q_ONE);
  endfunction

  // Build one random request: well-formed quadratics with known roots as the largest share,
  // then small-valued sets, raw full-range noise and a few degenerate a.
  task automatic random_request();
    int    pick, r1, r2, ai;
    coef_t a, b, c;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      ai = $urandom_range(1, 16) * (($urandom_range(0, 1) != 0) ? 1 : -1);
      r1 = $signed($urandom_range(0, 40)) - 20;
      r2 = ($urandom_range(0, 4) == 0) ? r1 : $signed($urandom_range(0, 40)) - 20;
      a  = ai * Q_ONE;
      b  = -ai * (r1 + r2) * Q_ONE;
      c  = ai * r1 * r2 * Q_ONE;
    end else if (pick < 70) begin
      a = small_q(8);
      b = small_q(64);
      c = small_q(64);
    end else if (pick < 95) begin
      a = $urandom();
      b = $urandom();
      c = $urandom();
    end else begin
      a = '0;
      b = $urandom();
      c = $urandom();
    end
    send_request(a, b, c);
  endtask

  initial begin
    int burst;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: degenerate a, no real roots, double root, two roots, extremes.
    send_request('0, '0, '0);
    send_request('0, 32'sh7fff_ffff, 32'sh8000_0000);
    send_request(Q_ONE, '0, Q_ONE);
    send_request(Q_ONE, 2 * Q_ONE, Q_ONE);
    send_request(-Q_ONE, 4 * Q_ONE, -4 * Q_ONE);
    send_request(Q_ONE, '0, -4 * Q_ONE);
    send_request(-Q_ONE, Q_ONE, 6 * Q_ONE);
    send_request(Q_ONE, -3 * Q_ONE, 2 * Q_ONE);
    send_request(32'sh0000_0001, 32'sh7fff_ffff, '0);
    send_request(32'sh0000_0001, 32'sh8000_0000, '0);
    send_request(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_request(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_request(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
    send_request(32'sh7fff_ffff, '0, 32'sh7fff_ffff);
    send_request(32'sh0000_0001, '0, 32'sh8000_0000);
    send_request(32'shffff_ffff, 32'shffff_ffff, 32'sh0000_0001);
    send_request(32'sh0000_0001, 32'sh0000_0002, 32'sh0000_0001);
    send_request(32'sh8000_0000, '0, '0);
    idle_cycles(3);

    // Random bursts with random gaps, including some back-to-back stretches.
    while (sent < RANDOM_ITEMS + 18) begin
      burst = $urandom_range(1, 24);
      repeat (burst) random_request();
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 15));
    end
    idle_cycles(0);

    // Drain the pipeline, then keep watching for stray strobes.
    do @(posedge clk); while (roots_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d coefficient sets (directed corners, built quadratics, noise);",
             sent);
    $display("checked %0d results, %0d mismatches.", roots_checked, mismatches);
    if (mismatches == 0 && roots_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: quadratic_root_solver.f
src/qrs_pkg.sv
src/qrs_sqrt.sv
src/qrs_div.sv
src/qrs_fifo.sv
src/qrs_front.sv
src/qrs_back.sv
src/quadratic_root_solver.sv
sim/qrs_root_checker.sv
sim/tb_quadratic_root_solver.sv
